[hw/rtl/bbrgb_pkg.sv]
// Shared types, constants and the reciprocal table of the 3x3 RGB box blur.
`default_nettype none
package bbrgb_pkg;

  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int TAPS      = 9;
  localparam int SUM_W     = 12;
  localparam int CNT_W     = 4;
  localparam int REC_W     = 24;
  localparam int REC_K     = 24;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic              action;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              frame_end;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_WAIT,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic                start;
    logic [TAPS-1:0]     mask;
    pixel_t [TAPS-1:0]   pixels;
  } mean_req_t;

  typedef struct packed {
    logic              done;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } mean_rsp_t;

  // ceil(2^24 / (2*count)); exact quotient for every numerator below 2^13
  function automatic logic [REC_W-1:0] mean_recip(input logic [CNT_W-1:0] cnt);
    logic [REC_W-1:0] m;
    case (cnt)
      4'd1:    m = 24'd8388608;
      4'd2:    m = 24'd4194304;
      4'd3:    m = 24'd2796203;
      4'd4:    m = 24'd2097152;
      4'd5:    m = 24'd1677722;
      4'd6:    m = 24'd1398102;
      4'd7:    m = 24'd1198373;
      4'd8:    m = 24'd1048576;
      4'd9:    m = 24'd932068;
      default: m = 24'd8388608;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bbrgb_mean.sv]
// Masked 3x3 sum and rounded mean per channel, two registered stages.
`default_nettype none
module bbrgb_mean (
  input  logic                  clk,
  input  logic                  rst,
  input  bbrgb_pkg::mean_req_t  req,
  output bbrgb_pkg::mean_rsp_t  rsp
);
  import bbrgb_pkg::*;

  logic                      sum_vld;
  logic [2:0][SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [2:0][SUM_W-1:0]     acc;
  logic [2:0][SUM_W:0]       num;
  logic [2:0][SUM_W+REC_W:0] prod;
  logic [REC_W-1:0]          rec;

  // lane 2 is red, lane 0 is blue
  always_comb begin
    acc = '0;
    for (int i = 0; i < TAPS; i++) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (req.mask[i]) begin
          acc[ch] = acc[ch] + SUM_W'(req.pixels[i][ch*CHAN_W +: CHAN_W]);
        end
      end
    end
  end

  // (2*sum + count) / (2*count) through the reciprocal table
  always_comb begin
    rec = mean_recip(cnt_q);
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = {sum_q[ch], 1'b0} + (SUM_W+1)'(cnt_q);
      prod[ch] = num[ch] * rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld  <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      sum_vld  <= req.start;
      rsp.done <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sum_q <= acc;
      cnt_q <= CNT_W'($countones(req.mask));
    end
    if (sum_vld) begin
      rsp.red   <= prod[2][REC_K +: CHAN_W];
      rsp.green <= prod[1][REC_K +: CHAN_W];
      rsp.blue  <= prod[0][REC_K +: CHAN_W];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/box_blur_3x3_rgb_unit.sv]
// Top level of the 3x3 RGB box blur: line store, window, counters and control.
//
//   channel  direction  handshake            beat
//   in       in         in_valid / in_stall   action, in_red, in_green, in_blue
//   out      out        out_valid / out_stall out_red, out_green, out_blue, frame_end
//   cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data (frame_width, frame_height)
//
// One beat at a time: a pixel with a result passes the read, calc, wait and hold
// states; one without passes read only; a drain beat while pixels are still due is
// dropped in idle. This follows the read-modify-write of the single-port line store
// and then the two-stage mean unit (masked sum, then reciprocal multiply).
// Reset clears counters and window; the line store is not cleared, since entries
// from outside the frame are masked. A stalled result waits in the output register.
`default_nettype none
module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bbrgb_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bbrgb_pkg::out_item_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbrgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbrgb_pkg::CFG_W-1:0]     cfg_data
);
  import bbrgb_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WIDTH_RST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int HEIGHT_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  state_t                 state, state_next;
  logic [WW-1:0]          frame_width;
  logic [HW-1:0]          frame_height;
  logic [PW-1:0]          frame_total;
  logic [CW-1:0]          col;
  logic [RW-1:0]          row;
  logic [PW-1:0]          out_pos;
  pixel_t [TAPS-1:0]      win;
  pixel_t                 newpx;
  logic [TAPS-1:0]        tap_mask;
  logic                   frame_end_q;

  // line store: upper half is the row above the middle row, lower half the middle row
  logic [2*PIX_W-1:0]     line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]     mem_rdata;
  logic                   mem_rd;
  logic                   mem_wr;

  mean_req_t              mean_req;
  mean_rsp_t              mean_rsp;

  logic                   in_fire;
  logic                   cfg_fire;
  logic                   pixel_phase;
  logic                   item_skip;
  logic [WW-1:0]          col_inc;
  logic                   emit_now;
  logic [RW-1:0]          orow;
  logic [WW-1:0]          ocol;
  logic [2:0]             row_ok;
  logic [2:0]             col_ok;
  logic [TAPS-1:0]        mask_now;
  logic [PW:0]            pos_inc;
  logic                   frame_last;
  logic                   out_free;
  logic [WW-1:0]          width_clamped;
  logic [HW-1:0]          height_clamped;

  assign cfg_ready   = 1'b1;
  assign cfg_fire    = cfg_valid && cfg_ready;
  assign in_fire     = in_valid && (state == S_IDLE);
  assign pixel_phase = row < RW'(frame_height);
  // drop a drain beat while frame pixels are still due
  assign item_skip   = pixel_phase && in_data.action;
  assign col_inc     = WW'(col) + WW'(1);
  assign emit_now    = (col != '0) ? (row >= RW'(1)) : (row >= RW'(2));
  assign pos_inc     = (PW+1)'(out_pos) + (PW+1)'(1);
  assign frame_last  = pos_inc >= (PW+1)'(frame_total);
  assign out_free    = !out_valid || !out_stall;

  // clamp register writes to 1..MAX
  always_comb begin
    if (cfg_data == '0) begin
      width_clamped  = WW'(1);
      height_clamped = HW'(1);
    end else begin
      width_clamped  = (32'(cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_data);
      height_clamped = (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
    end
  end

  // Output position: at the start of a row the result is the last pixel two rows up
  // and one column back wraps to the row's end.
  always_comb begin
    orow = (col != '0) ? (row - RW'(1)) : (row - RW'(2));
    ocol = (col != '0) ? (WW'(col) - WW'(1)) : (frame_width - WW'(1));
    row_ok[0] = orow != '0;
    row_ok[1] = orow < RW'(frame_height);
    row_ok[2] = ((RW+1)'(orow) + (RW+1)'(1)) < (RW+1)'(frame_height);
    col_ok[0] = ocol != '0;
    col_ok[1] = ocol < frame_width;
    col_ok[2] = ((WW+1)'(ocol) + (WW+1)'(1)) < (WW+1)'(frame_width);
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        mask_now[k*3 + j] = row_ok[k] & col_ok[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_stall        = 1'b1;
    mem_rd          = 1'b0;
    mem_wr          = 1'b0;
    mean_req.start  = 1'b0;
    mean_req.mask   = tap_mask;
    mean_req.pixels = win;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_fire && !item_skip) begin
          mem_rd     = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        mem_wr     = 1'b1;
        state_next = emit_now ? S_CALC : S_IDLE;
      end
      S_CALC: begin
        mean_req.start = 1'b1;
        state_next     = S_WAIT;
      end
      S_WAIT: begin
        if (mean_rsp.done) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // line store: read at the column on accept, write back the shifted pair in the cycle after
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      mem_rdata <= line_mem[col];
    end
    if (mem_wr) begin
      line_mem[col] <= {mem_rdata[PIX_W-1:0], newpx};
    end
  end

  // counters, window, frame registers, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WW'(WIDTH_RST);
      frame_height <= HW'(HEIGHT_RST);
      col          <= '0;
      row          <= '0;
      out_pos      <= '0;
      win          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_READ) begin
        // advance the window one column: upper, middle, then the new pixel
        for (int k = 0; k < 3; k++) begin
          win[k*3 + 0] <= win[k*3 + 1];
          win[k*3 + 1] <= win[k*3 + 2];
        end
        win[2] <= mem_rdata[2*PIX_W-1:PIX_W];
        win[5] <= mem_rdata[PIX_W-1:0];
        win[8] <= newpx;
        if (col_inc >= frame_width) begin
          col <= '0;
          row <= row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
      if (state == S_CALC) begin
        // the mean unit takes the window at this edge, so restart may clear it
        if (frame_last) begin
          col     <= '0;
          row     <= '0;
          out_pos <= '0;
          win     <= '0;
        end else begin
          out_pos <= PW'(pos_inc);
        end
      end
      if (state == S_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_fire) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            frame_width <= width_clamped;
            col         <= '0;
            row         <= '0;
            out_pos     <= '0;
            win         <= '0;
          end
          CFG_FRAME_HEIGHT: begin
            frame_height <= height_clamped;
            col          <= '0;
            row          <= '0;
            out_pos      <= '0;
            win          <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    frame_total <= PW'(frame_width) * PW'(frame_height);
    if (in_fire && !item_skip) begin
      // a pixel beat after the frame's last pixel counts as drain
      newpx <= pixel_phase ? {in_data.in_red, in_data.in_green, in_data.in_blue} : '0;
    end
    if (state == S_READ) begin
      tap_mask <= mask_now;
    end
    if (state == S_CALC) begin
      frame_end_q <= frame_last;
    end
    if (state == S_HOLD && out_free) begin
      out_data.out_red   <= mean_rsp.red;
      out_data.out_green <= mean_rsp.green;
      out_data.out_blue  <= mean_rsp.blue;
      out_data.frame_end <= frame_end_q;
    end
  end

  bbrgb_mean u_mean (
    .clk (clk),
    .rst (rst),
    .req (mean_req),
    .rsp (mean_rsp)
  );

  // a result enters the output register only from the hold state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_HOLD)
    else $error("result loaded outside hold state");

  // the mean unit finishes only while control waits for it
  assert property (@(posedge clk) disable iff (rst)
    mean_rsp.done |-> state == S_WAIT)
    else $error("mean result with no waiting beat");

  // a fresh frame end has already restarted the counters
  assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_data.frame_end) |-> (col == '0 && row == '0 && out_pos == '0))
    else $error("frame end without restart");

  // the input column stays inside the frame
  assert property (@(posedge clk) disable iff (rst)
    WW'(col) < frame_width)
    else $error("input column beyond frame width");

endmodule
`default_nettype wire

[tb/box_blur_3x3_rgb_check.sv]
// Checker for the 3x3 RGB box blur: predicts each blurred pixel and compares the out beats.
module box_blur_3x3_rgb_check #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  bbrgb_pkg::in_item_t             in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  bbrgb_pkg::out_item_t            out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bbrgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbrgb_pkg::CFG_W-1:0]     cfg_data,
  output int                              pending,
  output int                              errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import bbrgb_pkg::*;

  pixel_t           upper_row [MAX_WIDTH];
  pixel_t           middle_row [MAX_WIDTH];
  pixel_t           win [TAPS];
  int               col_at;
  int               row_at;
  int               out_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  out_item_t        blurred_q [$];
  out_item_t        want;
  int               fail_count;

  function automatic int bounded(input logic [CFG_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic restart_frame();
    col_at  = 0;
    row_at  = 0;
    out_pos = 0;
    foreach (win[k]) win[k] = '0;
  endtask

  // One input beat through the line stores and window; queue the blurred pixel it yields.
  task automatic advance_blur(input in_item_t beat);
    int        w, h, c, r, orow, ocol, rr, cc, cnt;
    int        sum_r, sum_g, sum_b;
    pixel_t    fresh, px;
    out_item_t res;
    w = bounded(width_reg, MAX_WIDTH);
    h = bounded(height_reg, MAX_HEIGHT);
    c = col_at;
    r = row_at;
    if (c >= w) c = 0;
    // drain while pixels are still due: no effect at all
    if (r < h && beat.action) return;
    // past the last row, anything counts as a drain and pushes black
    fresh = (r < h) ? {beat.in_red, beat.in_green, beat.in_blue} : '0;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2]        = upper_row[c];
    win[5]        = middle_row[c];
    win[8]        = fresh;
    upper_row[c]  = middle_row[c];
    middle_row[c] = fresh;
    if (c + 1 >= w) begin
      col_at = 0;
      row_at = r + 1;
    end else begin
      col_at = c + 1;
      row_at = r;
    end
    // the window center trails the input by one row and one pixel
    if (c >= 1) begin
      if (r < 1) return;
      orow = r - 1;
      ocol = c - 1;
    end else begin
      if (r < 2) return;
      orow = r - 2;
      ocol = w - 1;
    end
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt   = 0;
    for (int k = 0; k < 3; k++) begin
      rr = orow + k - 1;
      if (rr >= 0 && rr < h) begin
        for (int j = 0; j < 3; j++) begin
          cc = ocol + j - 1;
          if (cc >= 0 && cc < w) begin
            px    = win[k*3+j];
            sum_r += px[2*CHAN_W +: CHAN_W];
            sum_g += px[CHAN_W +: CHAN_W];
            sum_b += px[0 +: CHAN_W];
            cnt++;
          end
        end
      end
    end
    if (cnt == 0) cnt = 1;
    // round half up in integer
    res.out_red   = CHAN_W'((2 * sum_r + cnt) / (2 * cnt));
    res.out_green = CHAN_W'((2 * sum_g + cnt) / (2 * cnt));
    res.out_blue  = CHAN_W'((2 * sum_b + cnt) / (2 * cnt));
    if (out_pos + 1 >= w * h) begin
      res.frame_end = 1'b1;
      restart_frame();
    end else begin
      res.frame_end = 1'b0;
      out_pos++;
    end
    blurred_q.push_back(res);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (upper_row[k]) upper_row[k] = '0;
      foreach (middle_row[k]) middle_row[k] = '0;
      width_reg  = CFG_W'(MAX_WIDTH);
      height_reg = CFG_W'(MAX_HEIGHT);
      restart_frame();
      blurred_q.delete();
      fail_count = 0;
    end else begin
      // a result can never come from a beat taken at this same edge, so pop first
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected blurred pixel: expected none, actual r=%0d g=%0d b=%0d end=%0b",
                   $time, out_data.out_red, out_data.out_green, out_data.out_blue,
                   out_data.frame_end);
        end else begin
          want = blurred_q.pop_front();
          if (out_data.out_red !== want.out_red || out_data.out_green !== want.out_green ||
              out_data.out_blue !== want.out_blue ||
              out_data.frame_end !== want.frame_end) begin
            fail_count++;
            $display("%0t: blurred pixel mismatch: expected r=%0d g=%0d b=%0d end=%0b, %s",
                     $time, want.out_red, want.out_green, want.out_blue, want.frame_end,
                     $sformatf("actual r=%0d g=%0d b=%0d end=%0b", out_data.out_red,
                               out_data.out_green, out_data.out_blue, out_data.frame_end));
          end
        end
      end
      // any register write restarts the frame; line stores keep their contents
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            width_reg = cfg_data;
            restart_frame();
          end
          CFG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) advance_blur(in_data);
    end
    pending <= blurred_q.size();
    errors  <= fail_count;
  end

endmodule

[tb/box_blur_3x3_rgb_unit_tb.sv]
// Testbench top of the 3x3 RGB box blur: clock, reset, stimulus, watchdog and verdict.
module box_blur_3x3_rgb_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbrgb_pkg::*;

  localparam int   MAX_WIDTH      = 1024;
  localparam int   MAX_HEIGHT     = 1024;
  localparam int   RANDOM_PIXELS  = 600;
  localparam int   SETTLE_CYCLES  = 8;
  localparam int   FINAL_CYCLES   = 20;
  localparam int   WATCHDOG_LIMIT = 5000;
  localparam logic ACT_PIXEL      = 1'b0;
  localparam logic ACT_DRAIN      = 1'b1;

  // directed 3x3 frame: channel extremes, pure primaries and alternating bit patterns
  localparam pixel_t PROBE_PIX [9] = '{
    24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hAA55AA, 24'h55AA55, 24'hFFFFFF, 24'h010203
  };

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int                   pending;
  int                   errors;
  int                   idle_cycles = 0;
  int                   pixels_sent = 0;
  logic                 idling      = 1'b0;
  logic [CFG_W-1:0]     width_now   = CFG_W'(MAX_WIDTH);
  logic [CFG_W-1:0]     height_now  = CFG_W'(MAX_HEIGHT);

  box_blur_3x3_rgb_unit #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  box_blur_3x3_rgb_check #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pending  (pending),
    .errors   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run once nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall the out channel in random bursts while idling is on.
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int fit(input logic [CFG_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Lean toward the channel extremes now and then.
  function automatic logic [CHAN_W-1:0] rand_chan();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t rand_pixel();
    return in_item_t'{ACT_PIXEL, rand_chan(), rand_chan(), rand_chan()};
  endfunction

  // Channels of a drain beat are don't-care; randomize them anyway.
  function automatic in_item_t drain_beat();
    return in_item_t'{ACT_DRAIN, rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic in_item_t probe_beat(input pixel_t px);
    return in_item_t'{ACT_PIXEL, px[2*CHAN_W +: CHAN_W], px[CHAN_W +: CHAN_W], px[0 +: CHAN_W]};
  endfunction

  // Mostly small frames; a zero register value now and then (counts as one).
  function automatic logic [CFG_W-1:0] rand_dim(input int hi);
    if ($urandom_range(0, 9) == 0) return '0;
    return CFG_W'($urandom_range(1, hi));
  endfunction

  // Present one beat and hold it until taken; valid stays high for a following beat.
  task automatic push_beat(input in_item_t beat);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait out every expected pixel, then give beats without results time to finish.
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reshape(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
    settle(SETTLE_CYCLES);
    write_reg(CFG_FRAME_WIDTH, wv);
    write_reg(CFG_FRAME_HEIGHT, hv);
    cfg_valid  <= 1'b0;
    width_now  = wv;
    height_now = hv;
  endtask

  // One frame of random pixels, stray drains mixed in, then one row plus one pixel
  // of drains (some sent as pixels, which count as drains there). Abandon the frame
  // before pixel number cut when cut is not negative.
  task automatic blur_frame(input int cut);
    int w, h;
    w = fit(width_now, MAX_WIDTH);
    h = fit(height_now, MAX_HEIGHT);
    for (int i = 0; i < w * h; i++) begin
      if (i == cut) return;
      if ($urandom_range(0, 15) == 0) push_beat(drain_beat());
      push_beat(rand_pixel());
      pixels_sent++;
    end
    for (int i = 0; i <= w; i++)
      push_beat($urandom_range(0, 3) == 0 ? rand_pixel() : drain_beat());
    // a stray drain here falls into the next frame and must be ignored
    if ($urandom_range(0, 7) == 0) push_beat(drain_beat());
  endtask

  initial begin
    int start;
    int area;
    bit broke;
    repeat (9) @(posedge clk);
    rst    <= 1'b0;
    idling <= 1'b1;

    // Directed: a 3x3 frame covers corner, edge and center divisors.
    reshape(11'd3, 11'd3);
    for (int i = 0; i < 9; i++) begin
      // drain while pixels are due: ignored
      if (i == 4) push_beat(drain_beat());
      push_beat(probe_beat(PROBE_PIX[i]));
    end
    push_beat(drain_beat());
    // pixel after the last one: acts as a drain
    push_beat(probe_beat(24'hFFFFFF));
    push_beat(drain_beat());
    push_beat(drain_beat());
    // spare drain after the frame end: starts nothing
    push_beat(drain_beat());

    // Single-pixel frame, width register at zero.
    reshape(11'd0, 11'd1);
    push_beat(probe_beat(24'h7F8001));
    push_beat(drain_beat());
    push_beat(drain_beat());

    // Random frames of small sizes; some back to back with no register write,
    // some abandoned midway and restarted by a register write.
    start = pixels_sent;
    broke = 1'b0;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      idling <= ($urandom_range(0, 3) != 0);
      if (broke || $urandom_range(0, 2) != 0) reshape(rand_dim(12), rand_dim(8));
      area  = fit(width_now, MAX_WIDTH) * fit(height_now, MAX_HEIGHT);
      broke = ($urandom_range(0, 9) == 0);
      blur_frame(broke ? $urandom_range(0, area - 1) : -1);
    end

    // Largest shapes, all cut short: a full-width frame taken just past its first
    // row wrap, an oversized height on a single column, and an oversized width.
    idling <= 1'b1;
    reshape(11'd1024, 11'd2);
    blur_frame(MAX_WIDTH + $urandom_range(1, 16));
    reshape(11'd0, 11'd2047);
    blur_frame($urandom_range(1, 40));
    reshape(11'd2047, 11'd1);
    blur_frame($urandom_range(1, 40));

    // Tail: no idling on either side.
    idling <= 1'b0;
    repeat (6) begin
      reshape(rand_dim(12), rand_dim(8));
      blur_frame(-1);
    end

    settle(FINAL_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
